>>> src/weighted_load_balance_scheduler_top_assert.svh
// Assertion macros for the weighted load-balance scheduler.
`ifndef WEIGHTED_LOAD_BALANCE_SCHEDULER_TOP_ASSERT_SVH
`define WEIGHTED_LOAD_BALANCE_SCHEDULER_TOP_ASSERT_SVH
`ifndef SYNTH
`define WLB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define WLB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define WLB_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define WLB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> src/wlb_pkg.sv
// Shared constants, types and helpers of the load-balance scheduler.
`default_nettype none
package wlb_pkg;
	localparam int NPROC = 16;
	localparam int IW = $clog2(NPROC);
	localparam int PW = IW + 1;
	localparam int TOT_W = 37;
	localparam int SW_W = 21;
	localparam int W = 40;
	localparam int DVD_W = TOT_W + 16;
	localparam int DVS_W = SW_W;
	localparam int DC_W = $clog2(DVD_W + 1);

	typedef enum logic [14:0] {
		ST_LOAD  = 15'b000000000000001,
		ST_GRD   = 15'b000000000000010,
		ST_GMUL  = 15'b000000000000100,
		ST_GDIV  = 15'b000000000001000,
		ST_GWR   = 15'b000000000010000,
		ST_SA    = 15'b000000000100000,
		ST_SB    = 15'b000000001000000,
		ST_SC    = 15'b000000010000000,
		ST_SD    = 15'b000000100000000,
		ST_PTOP  = 15'b000001000000000,
		ST_PS    = 15'b000010000000000,
		ST_PIN   = 15'b000100000000000,
		ST_PR    = 15'b001000000000000,
		ST_PEMIT = 15'b010000000000000,
		ST_DONE  = 15'b100000000000000
	} state_t;

	function automatic logic [31:0] sat32(input logic signed [W-1:0] v);
		logic [31:0] r;
		if (v < 0) r = '0;
		else if (v > $signed({{(W-32){1'b0}}, 32'hFFFF_FFFF})) r = 32'hFFFF_FFFF;
		else r = v[31:0];
		return r;
	endfunction
endpackage
`default_nettype wire

>>> src/wlb_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module wlb_div import wlb_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic                  idle,
	output logic [DVD_W-1:0]      quotient
);
	logic [DC_W-1:0]  cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   trial;

	assign trial = {rem_q, quo_q[DVD_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (go) begin
			cnt_q <= DC_W'(DVD_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= DVS_W'(trial - {1'b0, dvs_q});
				quo_q <= {quo_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b0};
			end
		end
	end

	assign idle = (cnt_q == '0);
	assign quotient = quo_q;
endmodule
`default_nettype wire

>>> src/weighted_load_balance_scheduler_top.sv
// Loading takes one process per accepted start beat. After the last one, goals are
// computed per process by a bit-serial divider, the exchange sort steps through its
// compares, pairing visits each sender and each transfer, and results go one per strobe.
// One set is scheduled at a time; busy stays high from the last item to the final result.
// The receiver cannot stall; reset (arst_n low) returns to loading at index 0.
`default_nettype none
module weighted_load_balance_scheduler_top import wlb_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] work_count,
	input  wire logic [15:0] weight,
	input  wire logic        last_proc,
	output logic             strobe,
	output logic [4:0]       sender,
	output logic [4:0]       receiver,
	output logic [31:0]      amount,
	output logic             is_transfer,
	output logic             last_result
);
`include "weighted_load_balance_scheduler_top_assert.svh"

	state_t state_q;

	logic signed [W-1:0] held_q [NPROC];
	logic signed [W-1:0] goal_q [NPROC];
	logic signed [W-1:0] exc_q  [NPROC];
	logic [15:0]         wt_q   [NPROC];
	logic [IW-1:0]       ord_q  [NPROC];

	logic [PW-1:0] ld_q, n_q, i_q, j_q, start_q, last_q, zc_q;
	logic [TOT_W-1:0] total_q, sumg_q;
	logic [SW_W-1:0]  sumw_q;
	logic signed [W-1:0] h_q, ea_q, ts_q, tr_q, hr_q, left_q;
	logic [DVD_W-1:0] prod_q;
	logic [IW-1:0] a_q, b_q, s_q, r_q;
	logic flag_q, pend_q;
	logic [IW-1:0] ps_q, pr_q;
	logic [31:0]   pa_q;

	logic          div_go, div_idle;
	logic [DVD_W-1:0] div_q;
	logic signed [W-1:0] g_new, gs, hs, ts_new, trv, room, amt;
	logic          accept, end_set;

	wlb_div u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .dividend(prod_q),
		.divisor(sumw_q), .idle(div_idle), .quotient(div_q)
	);

	assign busy   = (state_q != ST_LOAD);
	assign accept = start && !busy;
	assign end_set = last_proc || (ld_q == PW'(NPROC - 1));
	assign div_go = (state_q == ST_GMUL);
	assign g_new  = (sumw_q == '0) ? '0 : $signed(W'(div_q[TOT_W-1:0]));
	assign gs     = goal_q[s_q];
	assign hs     = held_q[s_q];
	assign room   = $signed(W'(last_q)) - $signed(W'(start_q)) - $signed(W'(zc_q));
	assign amt    = (ts_q >= tr_q) ? tr_q : ts_q;

	always_comb begin
		ts_new = hs - gs;
		if (left_q > 0 && gs != '0) ts_new = ts_new - 1;
		trv = goal_q[r_q] - held_q[r_q];
		if (left_q >= room || flag_q) trv = trv + 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			ld_q <= '0;
			strobe <= 1'b0;
			pend_q <= 1'b0;
			flag_q <= 1'b0;
			left_q <= '0;
			zc_q <= '0;
		end else begin
			strobe <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (end_set) begin
							ld_q <= '0;
							n_q <= ld_q + 1'b1;
							i_q <= '0;
							zc_q <= '0;
							sumg_q <= '0;
							state_q <= ST_GRD;
						end else begin
							ld_q <= ld_q + 1'b1;
						end
					end
				end
				ST_GRD: begin
					h_q <= held_q[i_q[IW-1:0]];
					state_q <= ST_GMUL;
				end
				ST_GMUL: state_q <= ST_GDIV;
				ST_GDIV: if (div_idle) state_q <= ST_GWR;
				ST_GWR: begin
					sumg_q <= sumg_q + TOT_W'(g_new);
					if (g_new == '0) zc_q <= zc_q + 1'b1;
					if (i_q + 1'b1 < n_q) begin
						i_q <= i_q + 1'b1;
						state_q <= ST_GRD;
					end else begin
						left_q <= $signed(W'(total_q)) - $signed(W'(sumg_q)) - g_new;
						i_q <= '0;
						j_q <= PW'(1);
						start_q <= '0;
						last_q <= n_q - 1'b1;
						flag_q <= 1'b0;
						state_q <= (n_q > PW'(1)) ? ST_SA : ST_PTOP;
					end
				end
				ST_SA: begin
					a_q <= ord_q[i_q[IW-1:0]];
					state_q <= ST_SB;
				end
				ST_SB: begin
					b_q <= ord_q[j_q[IW-1:0]];
					ea_q <= exc_q[a_q];
					state_q <= ST_SC;
				end
				ST_SC, ST_SD: begin
					if (state_q == ST_SC && ea_q < exc_q[b_q]) begin
						state_q <= ST_SD;
					end else if (j_q + 1'b1 < n_q) begin
						j_q <= j_q + 1'b1;
						state_q <= ST_SA;
					end else if (i_q + PW'(2) < n_q) begin
						i_q <= i_q + 1'b1;
						j_q <= i_q + PW'(2);
						state_q <= ST_SA;
					end else begin
						state_q <= ST_PTOP;
					end
				end
				ST_PTOP: begin
					if (start_q < last_q) begin
						s_q <= ord_q[start_q[IW-1:0]];
						state_q <= ST_PS;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_PS: begin
					ts_q <= ts_new;
					if (left_q > 0 && gs != '0) left_q <= left_q - 1;
					state_q <= ST_PIN;
				end
				ST_PIN: begin
					if (ts_q > 0 && start_q != last_q) begin
						r_q <= ord_q[last_q[IW-1:0]];
						state_q <= ST_PR;
					end else begin
						start_q <= start_q + 1'b1;
						state_q <= ST_PTOP;
					end
				end
				ST_PR: begin
					tr_q <= trv;
					hr_q <= held_q[r_q];
					if (left_q >= room || flag_q) begin
						if (!flag_q) left_q <= left_q - 1;
						flag_q <= 1'b1;
					end
					state_q <= ST_PEMIT;
				end
				ST_PEMIT: begin
					// the previous transfer goes out now; this one waits to learn if it is final
					if (pend_q) begin
						strobe <= 1'b1;
						sender <= 5'(ps_q);
						receiver <= 5'(pr_q);
						amount <= pa_q;
						is_transfer <= 1'b1;
						last_result <= 1'b0;
					end
					pend_q <= 1'b1;
					ps_q <= s_q;
					pr_q <= r_q;
					pa_q <= sat32(amt);
					if (ts_q >= tr_q) begin
						ts_q <= ts_q - tr_q;
						last_q <= last_q - 1'b1;
						flag_q <= 1'b0;
					end else begin
						ts_q <= '0;
					end
					state_q <= ST_PIN;
				end
				ST_DONE: begin
					strobe <= 1'b1;
					last_result <= 1'b1;
					is_transfer <= pend_q;
					sender <= pend_q ? 5'(ps_q) : 5'd0;
					receiver <= pend_q ? 5'(pr_q) : 5'd0;
					amount <= pend_q ? pa_q : 32'd0;
					pend_q <= 1'b0;
					state_q <= ST_LOAD;
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// tables and running sums
	always_ff @(posedge clk) begin
		if (accept) begin
			held_q[ld_q[IW-1:0]] <= $signed(W'(work_count));
			wt_q[ld_q[IW-1:0]] <= weight;
			total_q <= ((ld_q == '0) ? '0 : total_q) + TOT_W'(work_count);
			sumw_q <= ((ld_q == '0) ? '0 : sumw_q) + SW_W'(weight);
		end
		// product is ready when the divider latches it at the end of ST_GMUL
		if (state_q == ST_GRD) prod_q <= DVD_W'(total_q * wt_q[i_q[IW-1:0]]);
		if (state_q == ST_GWR) begin
			goal_q[i_q[IW-1:0]] <= g_new;
			exc_q[i_q[IW-1:0]] <= h_q - g_new;
		end
		if (state_q == ST_PEMIT) held_q[r_q] <= hr_q + amt;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_GWR) ord_q[i_q[IW-1:0]] <= i_q[IW-1:0];
		else if (state_q == ST_SC && ea_q < exc_q[b_q]) ord_q[i_q[IW-1:0]] <= b_q;
		else if (state_q == ST_SD) ord_q[j_q[IW-1:0]] <= a_q;
	end

	`WLB_ASSERT_IMPLY(a_final_idle, clk, arst_n, strobe && last_result, !busy)
	`WLB_ASSERT_IMPLY(a_mid_busy, clk, arst_n, strobe && !last_result, busy)
	`WLB_ASSERT_IMPLY(a_marker_final, clk, arst_n, strobe && !is_transfer, last_result)
	`WLB_ASSERT_NEXT(a_sched_start, clk, arst_n, accept && end_set, state_q == ST_GRD)
endmodule
`default_nettype wire

>>> tb/sv/weighted_load_balance_scheduler_top_tb.sv
// Self-checking testbench for the weighted load-balance scheduler.
`timescale 1ns / 1ps
`default_nettype none
module weighted_load_balance_scheduler_top_tb;
	import wlb_pkg::*;

	localparam int CYCLE_LIMIT = 3_000_000;

	typedef struct {
		logic [4:0]  sender;
		logic [4:0]  receiver;
		logic [31:0] amount;
		logic        is_transfer;
		logic        last_result;
	} xfer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [31:0] work_count = '0;
	logic [15:0] weight = '0;
	logic        last_proc = 1'b0;
	wire         busy, strobe, is_transfer, last_result;
	wire  [4:0]  sender, receiver;
	wire  [31:0] amount;

	weighted_load_balance_scheduler_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.work_count(work_count), .weight(weight), .last_proc(last_proc),
		.strobe(strobe), .sender(sender), .receiver(receiver), .amount(amount),
		.is_transfer(is_transfer), .last_result(last_result)
	);

	always #5 clk = ~clk;

	// predictor state: the set being loaded
	logic [31:0] held_cells [NPROC];
	logic [15:0] proc_weight [NPROC];
	int          fill_index = 0;
	xfer_t       xfer_q [$];
	int          fail_count = 0;
	int          schedule_count = 0;
	int          transfer_count = 0;
	int          item_count = 0;
	bit          no_gaps = 1'b0;
	longint      cycle_count = 0;

	function automatic logic [31:0] clamp_amount(longint v);
		if (v < 0) return '0;
		if (v > longint'(32'hFFFF_FFFF)) return 32'hFFFF_FFFF;
		return v[31:0];
	endfunction

	function automatic void plan_schedule(int n);
		longint held [NPROC];
		longint goal [NPROC];
		int ord [NPROC];
		longint unsigned total, sum_w, sum_goal, g;
		longint leftover, front, back, give, take;
		int zero_goals, s, r, tmp;
		bit extra;
		xfer_t plan [$];
		xfer_t x;
		total = 0; sum_w = 0; sum_goal = 0; zero_goals = 0;
		for (int i = 0; i < n; i++) begin
			total += held_cells[i];
			sum_w += proc_weight[i];
		end
		for (int i = 0; i < n; i++) begin
			g = (sum_w != 0) ? (total * proc_weight[i]) / sum_w : 0;
			goal[i] = longint'(g);
			held[i] = longint'(held_cells[i]);
			sum_goal += g;
			if (g == 0) zero_goals++;
			ord[i] = i;
		end
		leftover = longint'(total - sum_goal);
		for (int i = 0; i < n; i++)
			for (int j = i + 1; j < n; j++)
				if (held[ord[i]] - goal[ord[i]] < held[ord[j]] - goal[ord[j]]) begin
					tmp = ord[i]; ord[i] = ord[j]; ord[j] = tmp;
				end
		extra = 1'b0;
		front = 0;
		back = n - 1;
		while (front < back) begin
			s = ord[front];
			give = held[s] - goal[s];
			if (leftover > 0 && goal[s] != 0) begin
				give--;
				leftover--;
			end
			while (give > 0 && front != back) begin
				r = ord[back];
				take = goal[r] - held[r];
				if (leftover >= back - front - zero_goals || extra) begin
					take++;
					if (!extra) leftover--;
					extra = 1'b1;
				end
				x.sender = s[4:0];
				x.receiver = r[4:0];
				x.is_transfer = 1'b1;
				x.last_result = 1'b0;
				if (give >= take) begin
					x.amount = clamp_amount(take);
					give -= take;
					held[s] -= take;
					held[r] += take;
					back--;
					extra = 1'b0;
				end else begin
					x.amount = clamp_amount(give);
					held[s] -= give;
					held[r] += give;
					give = 0;
				end
				plan.push_back(x);
			end
			front++;
		end
		if (plan.size() == 0) begin
			x = '{sender: '0, receiver: '0, amount: '0, is_transfer: 1'b0, last_result: 1'b0};
			plan.push_back(x);
		end
		plan[plan.size() - 1].last_result = 1'b1;
		transfer_count += (plan[0].is_transfer) ? plan.size() : 0;
		schedule_count++;
		foreach (plan[k]) xfer_q.push_back(plan[k]);
	endfunction

	// one beat to the block; start stays high on return
	task automatic send_proc(logic [31:0] cnt, logic [15:0] w, logic fin);
		@(negedge clk);
		start = 1'b1;
		work_count = cnt;
		weight = w;
		last_proc = fin;
		do @(posedge clk); while (busy);
		held_cells[fill_index] = cnt;
		proc_weight[fill_index] = w;
		item_count++;
		if (fin || fill_index == NPROC - 1) begin
			plan_schedule(fill_index + 1);
			fill_index = 0;
		end else
			fill_index++;
	endtask

	task automatic maybe_idle();
		if (!no_gaps)
			while ($urandom_range(99) < 32) begin
				@(negedge clk);
				start = 1'b0;
			end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start = 1'b0;
		while (xfer_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_count();
		case ($urandom_range(3))
			0: return $urandom_range(20);
			1: return $urandom_range(5000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] rand_weight();
		case ($urandom_range(4))
			0: return 16'd0;
			1: return 16'($urandom_range(8));
			default: return 16'($urandom_range(16'hFFFF));
		endcase
	endfunction

	task automatic send_set(int n, logic close);
		for (int i = 0; i < n; i++) begin
			maybe_idle();
			send_proc(rand_count(), rand_weight(), close && i == n - 1);
		end
	endtask

	task automatic test_single_proc();
		send_proc(32'd1234, 16'd7, 1'b1);
		send_proc(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
	endtask

	task automatic test_zero_weights();
		send_proc(32'd100, 16'd0, 1'b0);
		send_proc(32'd0, 16'd0, 1'b0);
		send_proc(32'd50, 16'd0, 1'b1);
	endtask

	task automatic test_extremes();
		send_proc(32'hFFFF_FFFF, 16'hFFFF, 1'b0);
		send_proc(32'd0, 16'd1, 1'b0);
		send_proc(32'd0, 16'hFFFF, 1'b0);
		send_proc(32'hFFFF_FFFF, 16'd0, 1'b1);
		// balanced set with leftovers
		send_proc(32'd10, 16'd3, 1'b0);
		send_proc(32'd10, 16'd3, 1'b0);
		send_proc(32'd11, 16'd3, 1'b1);
	endtask

	task automatic test_overlong_set();
		// sixteenth beat closes the set even with last_proc low
		for (int i = 0; i < NPROC; i++)
			send_proc(32'(i * 1000), 16'(i + 1), 1'b0);
		wait_drained();
	endtask

	task automatic test_random();
		int sets;
		sets = 0;
		while (item_count < 420) begin
			no_gaps = (sets >= 30 && sets < 50);
			if ($urandom_range(19) == 0)
				send_set(NPROC, 1'($urandom_range(1)));
			else
				send_set($urandom_range(1, 6), 1'b1);
			sets++;
			if (sets == 60) wait_drained();
		end
		no_gaps = 1'b0;
	endtask

	always @(posedge clk) begin
		xfer_t x;
		if (arst_n && strobe) begin
			if (xfer_q.size() == 0) begin
				$error("result beat with nothing expected");
				fail_count++;
			end else begin
				x = xfer_q.pop_front();
				if (sender !== x.sender) begin
					$error("sender: expected %0d, got %0d", x.sender, sender);
					fail_count++;
				end
				if (receiver !== x.receiver) begin
					$error("receiver: expected %0d, got %0d", x.receiver, receiver);
					fail_count++;
				end
				if (amount !== x.amount) begin
					$error("amount: expected %0d, got %0d", x.amount, amount);
					fail_count++;
				end
				if (is_transfer !== x.is_transfer) begin
					$error("is_transfer: expected %0b, got %0b", x.is_transfer, is_transfer);
					fail_count++;
				end
				if (last_result !== x.last_result) begin
					$error("last_result: expected %0b, got %0b", x.last_result, last_result);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("weighted_load_balance_scheduler_top_tb: errors");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_single_proc();
		test_zero_weights();
		test_extremes();
		test_overlong_set();
		test_random();
		wait_drained();
		repeat (200) @(posedge clk);
		if (xfer_q.size() != 0) begin
			$error("%0d expected results never arrived", xfer_q.size());
			fail_count++;
		end
		$display("Covered %0d beats in %0d schedules, %0d transfers predicted.",
			item_count, schedule_count, transfer_count);
		$display("Included single, zero-weight, extreme and overlong sets.");
		if (fail_count == 0)
			$display("weighted_load_balance_scheduler_top_tb: clean");
		else
			$display("weighted_load_balance_scheduler_top_tb: errors");
		$finish;
	end
endmodule
`default_nettype wire

>>> weighted_load_balance_scheduler_top.f
+incdir+src
src/wlb_pkg.sv
src/wlb_div.sv
src/weighted_load_balance_scheduler_top.sv
tb/sv/weighted_load_balance_scheduler_top_tb.sv
